FILE: hw/rtl/mss_pkg.sv
// Shared types and constants of the masked signature scanner.
// Used by mss_cfg, mss_cell and masked_signature_scanner_core.
package mss_pkg;

    localparam int SIG_BYTES  = 24;
    localparam int SIG_IDX_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int OFFSET_W   = 12;
    localparam int BASE_W     = 32;
    localparam int POS_W      = 32;
    localparam int RES_ADDR_W = 32;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_MID = 3'd1,
        REG_PAT_HI  = 3'd2,
        REG_CARE    = 3'd3,
        REG_LEN     = 3'd4,
        REG_OFFSET  = 3'd5,
        REG_BASE    = 3'd6
    } cfg_reg_t;

    // Compare setup for one window cell: expected byte and its care bit.
    typedef struct packed {
        byte_t sig;
        logic  care;
    } cell_cmp_t;

endpackage

FILE: hw/rtl/masked_signature_scanner_core.sv
// Masked signature scanner, top level.
// Depends on mss_pkg, mss_cfg and mss_cell.
//
// Usage:
//   Input stream s_*: one image byte per transfer in s_tdata[7:0]; s_tlast
//   marks the final byte of an image. Output stream m_*: at most one result
//   per image; m_tuser is found, m_tdata holds the match address (zero when
//   not found). The first matching window gives found=1; an image that ends
//   without a match gives found=0 on its final byte.
//   Configuration: cfg_we writes cfg_data to register cfg_index; the user must
//   raise cfg_we only while no image byte is in flight, as the block leaves this to the user.
// Timing:
//   One byte per cycle sustained while the output is not stalled. A byte
//   shifts into the cell row at its transfer, the masked compare and address
//   sum run on the next cycle and the result lands in the output register,
//   which drives m_tvalid. The cell row shift sets the rate.
// Reset and stall:
//   Reset clears the window, position, match flag and registers (length 1).
//   With m_tready low, a held result and one pending byte fill the pipe;
//   s_tready drops only when that byte would give another result.
module masked_signature_scanner_core
    import mss_pkg::*;
#(
    parameter int MAX_PATTERN  = 24,
    parameter int ADDRESS_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] data_byte
    input  logic                  s_tlast,    // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [31:0] match_address
    output logic [0:0]            m_tuser,    // [0] found
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (ADDRESS_BITS < RES_ADDR_W) ? ADDRESS_BITS : RES_ADDR_W;

    cell_cmp_t [MAX_PATTERN-1:0] cmp;
    logic [LW-1:0]               n_eff;
    logic [OFFSET_W-1:0]         offset;
    logic [BASE_W-1:0]           base;

    byte_t [MAX_PATTERN-1:0]     win;
    byte_t [MAX_PATTERN-1:0]     din;
    logic  [MAX_PATTERN-1:0]     miss;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_last_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            pos_next;
    logic                        rep_reg;
    logic                        rep_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        found_reg;
    logic [RES_ADDR_W-1:0]       addr_reg;

    logic                        accept;
    logic                        flush;
    logic                        hit;
    logic                        emit;
    logic                        out_free;
    logic                        s1_done;
    logic                        consume;
    logic                        load;
    logic [RES_ADDR_W-1:0]       sum;
    logic [RES_ADDR_W-1:0]       addr;

    mss_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmp       (cmp),
        .n_eff     (n_eff),
        .offset    (offset),
        .base      (base)
    );

    assign din[0] = accept ? s_tdata : '0;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        if (i > 0)
        begin : g_link
            assign din[i] = flush ? '0 : win[i-1];
        end
        mss_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (load),
            .din   (din[i]),
            .cmp   (cmp[i]),
            .q     (win[i]),
            .miss  (miss[i])
        );
    end

    assign hit  = !rep_reg && (pos_reg >= POS_W'(n_eff)) && (miss == '0);
    assign emit = s1_valid_reg && (hit || (s1_last_reg && !rep_reg));

    assign sum  = base + (pos_reg - POS_W'(n_eff)) + RES_ADDR_W'(offset);
    assign addr = hit ? RES_ADDR_W'(sum[AW-1:0]) : '0;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_done  = !emit || out_free;
    assign consume  = s1_valid_reg && s1_done;
    assign s_tready = !s1_valid_reg || s1_done;
    assign accept   = s_tvalid && s_tready;
    assign flush    = consume && s1_last_reg;
    assign load     = accept || flush;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (consume ? 1'b0 : s1_valid_reg);
        pos_next      = flush ? '0 : pos_reg;
        rep_next      = rep_reg;
        if (consume)
            rep_next = s1_last_reg ? 1'b0 : (rep_reg || hit);
        if (accept)
            pos_next = pos_next + POS_W'(1);
        out_valid_next = (consume && emit) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            pos_reg       <= '0;
            rep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                s1_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            found_reg <= hit;
            addr_reg  <= addr;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = addr_reg;
    assign m_tuser[0] = found_reg;

endmodule

FILE: hw/rtl/mss_cfg.sv
// Configuration registers and signature alignment for the scanner cells.
// Depends on mss_pkg.
module mss_cfg
    import mss_pkg::*;
#(
    parameter int MAX_PATTERN = 24
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data,
    output cell_cmp_t [MAX_PATTERN-1:0]            cmp,
    output logic [$clog2(MAX_PATTERN+1)-1:0]       n_eff,
    output logic [OFFSET_W-1:0]                    offset,
    output logic [BASE_W-1:0]                      base
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [CFG_DATA_W-1:0]          pat_lo_reg;
    logic [CFG_DATA_W-1:0]          pat_mid_reg;
    logic [CFG_DATA_W-1:0]          pat_hi_reg;
    logic [SIG_BYTES-1:0]           care_reg;
    logic [LEN_W-1:0]               len_reg;
    logic [OFFSET_W-1:0]            offset_reg;
    logic [BASE_W-1:0]              base_reg;
    logic [SIG_BYTES-1:0][7:0]      sig_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_mid_reg <= '0;
            pat_hi_reg  <= '0;
            care_reg    <= '0;
            len_reg     <= LEN_W'(1);
            offset_reg  <= '0;
            base_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAT_LO:  pat_lo_reg  <= cfg_data;
                REG_PAT_MID: pat_mid_reg <= cfg_data;
                REG_PAT_HI:  pat_hi_reg  <= cfg_data;
                REG_CARE:    care_reg    <= cfg_data[SIG_BYTES-1:0];
                REG_LEN:     len_reg     <= cfg_data[LEN_W-1:0];
                REG_OFFSET:  offset_reg  <= cfg_data[OFFSET_W-1:0];
                REG_BASE:    base_reg    <= cfg_data[BASE_W-1:0];
                default:     ;
            endcase
        end
    end

    assign sig_w  = {pat_hi_reg, pat_mid_reg, pat_lo_reg};
    assign offset = offset_reg;
    assign base   = base_reg;

    always_comb
    begin
        if (len_reg == '0)
            n_eff = LW'(1);
        else if (int'(len_reg) > MAX_PATTERN)
            n_eff = LW'(MAX_PATTERN);
        else
            n_eff = LW'(len_reg);
    end

    // Cell i holds the byte taken i transfers ago; it meets signature byte n-1-i.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cmp[i] = '0;
            if (i < int'(n_eff) && (int'(n_eff) - 1 - i) < SIG_BYTES)
            begin
                cmp[i].sig  = sig_w[SIG_IDX_W'(int'(n_eff) - 1 - i)];
                cmp[i].care = care_reg[SIG_IDX_W'(int'(n_eff) - 1 - i)];
            end
        end
    end

endmodule

FILE: hw/rtl/mss_cell.sv
// One window cell: holds one image byte, passes it on, flags a masked mismatch.
// Depends on mss_pkg.
module mss_cell
    import mss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  byte_t     din,
    input  cell_cmp_t cmp,
    output byte_t     q,
    output logic      miss
);

    byte_t byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else if (load)
            byte_reg <= din;
    end

    assign q    = byte_reg;
    assign miss = cmp.care && (byte_reg != cmp.sig);

endmodule

FILE: sim/masked_signature_scanner_core_test.sv
// Self-checking testbench for masked_signature_scanner_core: a directed table, a stalled-output
// phase and random images, each result checked against typed table rows or a scan predictor kept in this file.
// Depends on mss_pkg and the scanner RTL.
module masked_signature_scanner_core_test
    import mss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PLAN_ROWS     = 39;
    localparam int TOTAL_BYTES   = 1300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PRESSURE_HOLD = 400;
    localparam int STALL_LIMIT   = 4000;

    typedef enum logic [2:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_HIT,
        ROW_MISS,
        ROW_QUIET
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_sel;
        logic [CFG_DATA_W-1:0]    value;
        logic                     last;
        logic [RES_ADDR_W-1:0]    addr;
    } plan_row_t;

    typedef struct packed {
        logic                  found;
        logic [RES_ADDR_W-1:0] addr;
    } scan_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // scanner state and registers as the predictor sees them
    byte_t                 scan_window [SIG_BYTES];
    logic [POS_W-1:0]      scan_count;
    logic                  scan_matched;
    logic [63:0]           sig_lo;
    logic [63:0]           sig_mid;
    logic [63:0]           sig_hi;
    logic [SIG_BYTES-1:0]  care_bits;
    logic [LEN_W-1:0]      sig_len_reg;
    logic [OFFSET_W-1:0]   addr_offset;
    logic [BASE_W-1:0]     image_base;

    scan_result_t          pending_matches [$];
    plan_row_t             plan [0:PLAN_ROWS-1];
    int                    mismatches;
    int                    bytes_sent;
    int                    idle_cycles;
    int                    ready_hold;
    int                    recv_cycle;
    bit                    sender_calm;
    bit                    recv_calm;
    bit                    pressure_req;
    bit                    pressure_taken;

    masked_signature_scanner_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_image();
        for (int i = 0; i < SIG_BYTES; i++)
            scan_window[i] = '0;
        scan_count   = '0;
        scan_matched = 1'b0;
    endfunction

    function automatic void reset_scanner();
        sig_lo      = '0;
        sig_mid     = '0;
        sig_hi      = '0;
        care_bits   = '0;
        sig_len_reg = LEN_W'(1);
        addr_offset = '0;
        image_base  = '0;
        clear_image();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] sel, input logic [63:0] v);
        case (sel)
            REG_PAT_LO:  sig_lo      = v;
            REG_PAT_MID: sig_mid     = v;
            REG_PAT_HI:  sig_hi      = v;
            REG_CARE:    care_bits   = v[SIG_BYTES-1:0];
            REG_LEN:     sig_len_reg = v[LEN_W-1:0];
            REG_OFFSET:  addr_offset = v[OFFSET_W-1:0];
            REG_BASE:    image_base  = v[BASE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int eff_len();
        int n;
        n = sig_len_reg;
        if (n == 0)
            n = 1;
        if (n > SIG_BYTES)
            n = SIG_BYTES;
        return n;
    endfunction

    function automatic byte_t sig_byte(input int k);
        logic [8*SIG_BYTES-1:0] all_bytes;
        all_bytes = {sig_hi, sig_mid, sig_lo};
        return all_bytes[8*k +: 8];
    endfunction

    function automatic void scan_byte(input byte_t d, input logic l,
                                      output logic got, output scan_result_t r);
        int               n;
        bit               hit;
        logic [POS_W-1:0] start;
        n = eff_len();
        for (int i = SIG_BYTES - 1; i > 0; i--)
            scan_window[i] = scan_window[i-1];
        scan_window[0] = d;
        scan_count     = scan_count + 1'b1;
        got            = 1'b0;
        r              = '0;
        if (!scan_matched && scan_count >= POS_W'(n))
        begin
            hit = 1'b1;
            for (int k = 0; k < n; k++)
                if (care_bits[k] && scan_window[n-1-k] != sig_byte(k))
                    hit = 1'b0;
            if (hit)
            begin
                start        = scan_count - POS_W'(n);
                r.found      = 1'b1;
                r.addr       = image_base + start + RES_ADDR_W'(addr_offset);
                scan_matched = 1'b1;
                got          = 1'b1;
            end
        end
        if (l)
        begin
            if (!scan_matched)
            begin
                r   = '0;
                got = 1'b1;
            end
            clear_image();
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (sender_calm || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= v;
        @(posedge clk);
        apply_reg(sel, v);
    endtask

    task automatic send_byte(input byte_t d, input logic l, input row_kind_t how,
                             input logic [RES_ADDR_W-1:0] typed_addr);
        int           gap;
        logic         got;
        scan_result_t r;
        scan_result_t typed;
        gap = sender_gap();
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        scan_byte(d, l, got, r);
        typed = '0;
        case (how)
            ROW_HIT:
            begin
                typed.found = 1'b1;
                typed.addr  = typed_addr;
                pending_matches.push_back(typed);
            end
            ROW_MISS:  pending_matches.push_back(typed);
            ROW_QUIET: ;
            default:   if (got) pending_matches.push_back(r);
        endcase
    endtask

    task automatic drain_scan();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic scan_image(input int len, input bit plant);
        int    n;
        int    start;
        byte_t b;
        n     = eff_len();
        start = -1;
        if (plant && len >= n)
            start = $urandom_range(0, len - n);
        for (int k = 0; k < len; k++)
        begin
            if (start >= 0 && k >= start && k < start + n && care_bits[k - start])
                b = sig_byte(k - start);
            else if ($urandom_range(0, 3) == 0)
                b = sig_byte($urandom_range(0, n - 1));
            else
                b = byte_t'($urandom);
            send_byte(b, k == len - 1, ROW_PREDICT, '0);
        end
    endtask

    task automatic shuffle_regs();
        int          r;
        logic [63:0] v;
        drain_scan();
        write_reg(REG_PAT_LO,  {$urandom, $urandom});
        write_reg(REG_PAT_MID, {$urandom, $urandom});
        write_reg(REG_PAT_HI,  {$urandom, $urandom});
        r = $urandom_range(0, 9);
        if (r < 3)
            v = {$urandom, $urandom};
        else if (r < 6)
            v = {32'd0, $urandom & $urandom};
        else if (r < 8)
            v = 64'hFF_FFFF;
        else if (r < 9)
            v = '0;
        else
            v = '1;
        write_reg(REG_CARE, v);
        r = $urandom_range(0, 19);
        if (r < 13)
            v = 64'($urandom_range(1, 6));
        else if (r < 16)
            v = 64'($urandom_range(7, 23));
        else if (r < 18)
            v = 64'(SIG_BYTES);
        else
            v = {$urandom, $urandom};
        write_reg(REG_LEN, v);
        r = $urandom_range(0, 3);
        write_reg(REG_OFFSET, (r == 0) ? 64'hFFF : (r == 1) ? 64'd0 : {$urandom, $urandom});
        r = $urandom_range(0, 4);
        if (r == 0)
            v = 64'hFFFF_FFFF;
        else if (r == 1)
            v = 64'(32'hFFFF_FF00 | $urandom_range(0, 255));
        else if (r == 2)
            v = '0;
        else
            v = {$urandom, $urandom};
        write_reg(REG_BASE, v);
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    // receiver: random backpressure and result check
    initial
    begin
        scan_result_t want;
        m_tready       = 1'b0;
        ready_hold     = 0;
        recv_cycle     = 0;
        recv_calm      = 1'b0;
        pressure_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_matches.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0b addr=%h",
                             $time, m_tuser[0], m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (m_tuser[0] !== want.found)
                    begin
                        $display("%0t: found mismatch expected %0b actual %0b",
                                 $time, want.found, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata !== want.addr)
                    begin
                        $display("%0t: match_address mismatch expected %h actual %h",
                                 $time, want.addr, m_tdata);
                        mismatches++;
                    end
                end
            end
            recv_cycle++;
            if (recv_cycle % 250 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            if (ready_hold > 0)
            begin
                ready_hold--;
                m_tready <= 1'b0;
            end
            else if (pressure_req && !pressure_taken)
            begin
                pressure_taken = 1'b1;
                ready_hold     = PRESSURE_HOLD;
                m_tready <= 1'b0;
            end
            else if (!recv_calm && $urandom_range(0, 99) < 20)
            begin
                ready_hold = idle_len() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        bit prev_byte;
        int n;
        int r;
        int len;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        bytes_sent   = 0;
        sender_calm  = 1'b0;
        pressure_req = 1'b0;
        reset_scanner();

        plan = '{
            // reset values: length 1, all wildcards, base and offset zero
            '{ROW_HIT,   REG_PAT_LO,  64'h00, 1'b0, 32'h0},
            '{ROW_QUIET, REG_PAT_LO,  64'hFF, 1'b1, 32'h0},
            '{ROW_HIT,   REG_PAT_LO,  64'hA5, 1'b1, 32'h0},
            // wildcard in the middle, address wraps at 32 bits
            '{ROW_CFG,   REG_PAT_LO,  64'h0000_0000_00FF_00FF, 1'b0, 32'h0},
            '{ROW_CFG,   REG_CARE,    64'h5, 1'b0, 32'h0},
            '{ROW_CFG,   REG_LEN,     64'd3, 1'b0, 32'h0},
            '{ROW_CFG,   REG_OFFSET,  64'hFFF, 1'b0, 32'h0},
            '{ROW_CFG,   REG_BASE,    64'hFFFF_FFFF, 1'b0, 32'h0},
            '{ROW_QUIET, REG_PAT_LO,  64'hFF, 1'b0, 32'h0},
            '{ROW_QUIET, REG_PAT_LO,  64'h12, 1'b0, 32'h0},
            '{ROW_HIT,   REG_PAT_LO,  64'hFF, 1'b0, 32'h0000_0FFE},
            '{ROW_QUIET, REG_PAT_LO,  64'h00, 1'b1, 32'h0},
            '{ROW_MISS,  REG_PAT_LO,  64'hFF, 1'b1, 32'h0},
            // length zero acts as one, care bits above the signature dropped
            '{ROW_CFG,   REG_PAT_LO,  64'h78, 1'b0, 32'h0},
            '{ROW_CFG,   REG_CARE,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
            '{ROW_CFG,   REG_LEN,     64'd0, 1'b0, 32'h0},
            '{ROW_CFG,   REG_OFFSET,  64'd0, 1'b0, 32'h0},
            '{ROW_CFG,   REG_BASE,    64'h1000, 1'b0, 32'h0},
            '{ROW_QUIET, REG_PAT_LO,  64'h00, 1'b0, 32'h0},
            '{ROW_HIT,   REG_PAT_LO,  64'h78, 1'b0, 32'h0000_1001},
            '{ROW_QUIET, REG_PAT_LO,  64'h78, 1'b1, 32'h0},
            '{ROW_MISS,  REG_PAT_LO,  64'h00, 1'b1, 32'h0},
            // length above the maximum, image shorter than the signature
            '{ROW_CFG,   REG_LEN,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
            '{ROW_CFG,   REG_CARE,    64'd0, 1'b0, 32'h0},
            '{ROW_CFG,   REG_UNUSED,  64'hDEAD_BEEF_0123_4567, 1'b0, 32'h0},
            '{ROW_CFG,   REG_PAT_MID, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
            '{ROW_CFG,   REG_PAT_HI,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
            '{ROW_QUIET, REG_PAT_LO,  64'h55, 1'b0, 32'h0},
            '{ROW_QUIET, REG_PAT_LO,  64'hAA, 1'b0, 32'h0},
            '{ROW_MISS,  REG_PAT_LO,  64'h01, 1'b1, 32'h0},
            // two care bytes, match after a false start
            '{ROW_CFG,   REG_PAT_LO,  64'h3412, 1'b0, 32'h0},
            '{ROW_CFG,   REG_CARE,    64'h3, 1'b0, 32'h0},
            '{ROW_CFG,   REG_LEN,     64'd2, 1'b0, 32'h0},
            '{ROW_CFG,   REG_OFFSET,  64'h123, 1'b0, 32'h0},
            '{ROW_CFG,   REG_BASE,    64'h8000_0000, 1'b0, 32'h0},
            '{ROW_PREDICT, REG_PAT_LO, 64'h12, 1'b0, 32'h0},
            '{ROW_PREDICT, REG_PAT_LO, 64'h12, 1'b0, 32'h0},
            '{ROW_PREDICT, REG_PAT_LO, 64'h34, 1'b0, 32'h0},
            '{ROW_PREDICT, REG_PAT_LO, 64'h56, 1'b1, 32'h0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_byte = 1'b0;
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (prev_byte)
                    drain_scan();
                prev_byte = 1'b0;
                write_reg(plan[i].reg_sel, plan[i].value);
            end
            else
            begin
                prev_byte = 1'b1;
                send_byte(plan[i].value[7:0], plan[i].last, plan[i].kind, plan[i].addr);
            end
        end

        // hold off the output while every short image hits on its first byte
        drain_scan();
        write_reg(REG_LEN, 64'd1);
        write_reg(REG_CARE, 64'd0);
        sender_calm  = 1'b1;
        pressure_req = 1'b1;
        repeat (40) scan_image(2, 1'b0);
        sender_calm = 1'b0;

        while (bytes_sent < TOTAL_BYTES)
        begin
            shuffle_regs();
            n = eff_len();
            repeat ($urandom_range(3, 10))
            begin
                sender_calm = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                if (r < 75)
                    len = $urandom_range(1, n + 6);
                else
                    len = $urandom_range(n, 2 * n + 20);
                scan_image(len, $urandom_range(0, 9) < 7);
            end
        end

        drain_scan();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mss_pkg.sv
hw/rtl/mss_cfg.sv
hw/rtl/mss_cell.sv
hw/rtl/masked_signature_scanner_core.sv
sim/masked_signature_scanner_core_test.sv
